// ===== design/mdc_pkg.sv =====
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types, widths, constants and helpers of the metered dispense
// controller.
// ----------------------------------------------------------------------------
package mdc_pkg;

  localparam int STEP_W = 7;   // encoder step, signed
  localparam int TGT_W  = 24;  // target volume, ml
  localparam int VOL_W  = 25;  // dispensed volume, ml
  localparam int REL_W  = 17;  // relative tick counter, signed
  localparam int TICK_W = 16;  // non-negative tick count
  localparam int TP_W   = 15;  // ticks of the partial sum, below the fold point
  localparam int ML_W   = 17;  // ml of one partial sum
  localparam int MODE_W = 3;

  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  // counter saturation; the _X bounds are one bit wider than the counter
  localparam logic signed [REL_W:0]   REL_MIN_X  = -18'sd32767;
  localparam logic signed [REL_W:0]   REL_MAX_X  = 18'sd32768;
  localparam logic signed [REL_W-1:0] REL_MIN    = -17'sd32767;
  localparam logic signed [REL_W-1:0] REL_MAX    = 17'sd32768;
  localparam logic signed [REL_W-1:0] FILT_HI    = 17'sd10;
  localparam logic signed [REL_W-1:0] FILT_LO    = -17'sd10;

  localparam logic [TICK_W-1:0] FOLD_TICKS   = 16'd30000;
  localparam logic [TGT_W-1:0]  MIN_TARGET   = 24'd100;
  localparam logic [TGT_W-1:0]  SLOW_MARGIN  = 24'd1000;

  // valve_state bits
  localparam int VALVE_PUMP = 0;
  localparam int VALVE_MAIN = 1;
  localparam int VALVE_AUX  = 2;

  // mode codes as seen on the result channel
  localparam logic [MODE_W-1:0] MODE_CODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_START = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_WORK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_STOP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_ERROR = 3'd4;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_START = 5'b00010,
    MODE_WORK  = 5'b00100,
    MODE_STOP  = 5'b01000,
    MODE_ERROR = 5'b10000
  } mode_t;

  // input item, laid out as on in_tdata (encoder_step in the low bits)
  typedef struct packed {
    logic                     stop_request;
    logic                     start_request;
    logic                     error_active;
    logic                     gun_ready;
    logic signed [STEP_W-1:0] encoder_step;
  } in_item_t;

  // result item, laid out as on out_tdata (pump_on in bit 0)
  typedef struct packed {
    logic [VOL_W-1:0]  dispensed_volume;
    logic [MODE_W-1:0] mode;
    logic              aux_valve_on;
    logic              main_valve_on;
    logic              pump_on;
  } result_t;

  // volume datapath, work mode
  typedef struct packed {
    logic signed [REL_W-1:0] rel;
    logic [TP_W-1:0]         tp;
    logic [VOL_W-1:0]        vb;
    logic [ML_W-1:0]         vp;
    logic [TGT_W-1:0]        target;
  } vol_in_t;

  typedef struct packed {
    logic signed [REL_W-1:0] rel;
    logic [TP_W-1:0]         tp;
    logic [VOL_W-1:0]        vb;
    logic [ML_W-1:0]         vp;
    logic                    main_off;
    logic                    done;
  } vol_out_t;

  // ticks * 25 / 10 == ticks * 5 / 2, truncated
  function automatic logic [ML_W-1:0] ticks_to_ml(input logic [TICK_W-1:0] t);
    logic [ML_W:0] x5;
    x5 = {2'b00, t} + {t, 2'b00};
    return x5[ML_W:1];
  endfunction

  function automatic logic [VOL_W-1:0] sat_vol(input logic [VOL_W-1:0] a,
                                               input logic [ML_W-1:0]  b);
    logic [VOL_W:0] s;
    s = {1'b0, a} + (VOL_W+1)'(b);
    return s[VOL_W] ? VOL_MAX : s[VOL_W-1:0];
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_IDLE:  c = MODE_CODE_IDLE;
      MODE_START: c = MODE_CODE_START;
      MODE_WORK:  c = MODE_CODE_WORK;
      MODE_STOP:  c = MODE_CODE_STOP;
      MODE_ERROR: c = MODE_CODE_ERROR;
      default:    c = MODE_CODE_STOP;
    endcase
    return c;
  endfunction

endpackage

// ===== design/mdc_volume.sv =====
// ----------------------------------------------------------------------------
// mdc_volume
// Work-mode volume update: dead band, backward-motion undo, fold of the
// partial sums and valve / target checks.
// ----------------------------------------------------------------------------
module mdc_volume (
  input  mdc_pkg::vol_in_t  vi,
  output mdc_pkg::vol_out_t vo
);
  import mdc_pkg::*;

  logic signed [REL_W-1:0] pre;
  logic                    forced;
  logic signed [REL_W-1:0] rel2;
  logic [TICK_W-1:0]       f;
  logic [ML_W-1:0]         pre_ml;
  logic [ML_W-1:0]         f_ml;
  logic [VOL_W-1:0]        total;
  logic [VOL_W-1:0]        total_new;
  logic [TGT_W-1:0]        fast;
  logic                    skip_eq;
  logic                    fold;

  always_comb begin
    pre     = (vi.rel >= FILT_LO && vi.rel <= FILT_HI) ? '0 : vi.rel;
    forced  = pre < $signed({2'b00, vi.tp});
    rel2    = forced ? $signed({2'b00, vi.tp}) : vi.rel;
    // not forced means pre >= tp >= 0
    f       = forced ? {1'b0, vi.tp} : pre[TICK_W-1:0];
    pre_ml  = ticks_to_ml(pre[TICK_W-1:0]);
    f_ml    = ticks_to_ml(f);
    total   = sat_vol(vi.vb, vi.vp);
    total_new = sat_vol(vi.vb, f_ml);
    fast    = (vi.target > SLOW_MARGIN) ? vi.target - SLOW_MARGIN : '0;
    skip_eq = !pre[REL_W-1] && ({(VOL_W-ML_W)'(0), pre_ml} == total);
    fold    = f >= FOLD_TICKS;

    vo.rel      = rel2;
    vo.tp       = vi.tp;
    vo.vb       = vi.vb;
    vo.vp       = vi.vp;
    vo.main_off = 1'b0;
    vo.done     = 1'b0;

    if (skip_eq) begin
      vo.rel = rel2;
    end else if (fold) begin
      // no valve or target check on the fold tick
      vo.rel = '0;
      vo.vb  = total;
      vo.vp  = '0;
      vo.tp  = '0;
    end else if (vi.vp != f_ml) begin
      vo.vp       = f_ml;
      vo.tp       = f[TP_W-1:0];
      vo.main_off = total_new >= {1'b0, fast};
      vo.done     = total_new >= {1'b0, vi.target};
    end
  end

endmodule

// ===== design/mdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdc_ctrl
// Mode sequencer and run state; computes one result per stepped item.
// ----------------------------------------------------------------------------
module mdc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  mdc_pkg::in_item_t         item,
  input  logic                      cfg_we,
  input  logic [mdc_pkg::TGT_W-1:0] cfg_data,
  output mdc_pkg::result_t          res
);
  import mdc_pkg::*;

  mode_t                   mode_r, mode_nxt;
  logic signed [REL_W-1:0] rel_r, rel_nxt;
  logic [TP_W-1:0]         tp_r, tp_nxt;
  logic [VOL_W-1:0]        vb_r, vb_nxt;
  logic [ML_W-1:0]         vp_r, vp_nxt;
  logic                    start_pend_r, start_pend_nxt;
  logic                    stop_pend_r, stop_pend_nxt;
  logic [2:0]              valve_r, valve_nxt;
  logic [TGT_W-1:0]        target_r, target_nxt;

  logic signed [REL_W:0]   rel_sum;
  logic signed [REL_W-1:0] rel1;
  logic                    start1;
  logic                    stop1;
  vol_in_t                 vi;
  vol_out_t                vo;

  // counter accumulate with saturation
  always_comb begin
    rel_sum = (REL_W+1)'(rel_r) + (REL_W+1)'(item.encoder_step);
    if (rel_sum < REL_MIN_X) begin
      rel1 = REL_MIN;
    end else if (rel_sum > REL_MAX_X) begin
      rel1 = REL_MAX;
    end else begin
      rel1 = rel_sum[REL_W-1:0];
    end
  end

  // stop request overrides a start in the same item
  assign start1 = item.stop_request ? 1'b0 : (start_pend_r | item.start_request);
  assign stop1  = stop_pend_r | item.stop_request;

  assign vi.rel    = rel1;
  assign vi.tp     = tp_r;
  assign vi.vb     = vb_r;
  assign vi.vp     = vp_r;
  assign vi.target = target_r;

  mdc_volume u_volume (
    .vi (vi),
    .vo (vo)
  );

  always_comb begin
    mode_nxt       = mode_r;
    rel_nxt        = rel1;
    tp_nxt         = tp_r;
    vb_nxt         = vb_r;
    vp_nxt         = vp_r;
    start_pend_nxt = start1;
    stop_pend_nxt  = stop1;
    valve_nxt      = valve_r;
    target_nxt     = target_r;

    unique case (mode_r)
      MODE_IDLE: begin
        if (item.error_active) begin
          mode_nxt = MODE_ERROR;
        end else if (stop1) begin
          mode_nxt = MODE_STOP;
        end else if (start1) begin
          mode_nxt = MODE_START;
        end
      end
      MODE_START: begin
        if (target_r < MIN_TARGET) begin
          target_nxt = '0;
          mode_nxt   = MODE_IDLE;
        end else if (item.gun_ready) begin
          start_pend_nxt = 1'b0;
          stop_pend_nxt  = 1'b0;
          tp_nxt         = '0;
          vb_nxt         = '0;
          vp_nxt         = '0;
          rel_nxt        = '0;
          valve_nxt      = 3'b111;
          mode_nxt       = MODE_WORK;
        end
      end
      MODE_WORK: begin
        if (!item.gun_ready) begin
          mode_nxt = MODE_STOP;
        end else begin
          rel_nxt = vo.rel;
          tp_nxt  = vo.tp;
          vb_nxt  = vo.vb;
          vp_nxt  = vo.vp;
          if (vo.main_off) begin
            valve_nxt[VALVE_MAIN] = 1'b0;
          end
          if (stop1 || vo.done) begin
            mode_nxt = MODE_STOP;
          end
        end
      end
      MODE_ERROR: begin
        valve_nxt = '0;
        if (!item.error_active) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_STOP: begin
        valve_nxt = '0;
        mode_nxt  = MODE_IDLE;
      end
      default: begin
        valve_nxt = '0;
        mode_nxt  = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    res.pump_on          = valve_nxt[VALVE_PUMP];
    res.main_valve_on    = valve_nxt[VALVE_MAIN];
    res.aux_valve_on     = valve_nxt[VALVE_AUX];
    res.mode             = mode_code(mode_nxt);
    res.dispensed_volume = sat_vol(vb_nxt, vp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_STOP;
      rel_r        <= '0;
      tp_r         <= '0;
      vb_r         <= '0;
      vp_r         <= '0;
      start_pend_r <= 1'b0;
      stop_pend_r  <= 1'b0;
      valve_r      <= '0;
    end else if (step_en) begin
      mode_r       <= mode_nxt;
      rel_r        <= rel_nxt;
      tp_r         <= tp_nxt;
      vb_r         <= vb_nxt;
      vp_r         <= vp_nxt;
      start_pend_r <= start_pend_nxt;
      stop_pend_r  <= stop_pend_nxt;
      valve_r      <= valve_nxt;
    end
  end

  // target: host writes, cleared by a rejected start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= cfg_data;
    end else if (step_en) begin
      target_r <= target_nxt;
    end
  end

endmodule

// ===== design/metered_dispense_controller_unit.sv =====
// ----------------------------------------------------------------------------
// metered_dispense_controller_unit
// Volume-dispensing sequencer: one poll item per tick in, one status item out.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*  : one poll item per meter tick (encoder step, gun, error, start
//            and stop requests). Accepted when in_tvalid && in_tready.
//  - out_* : one status item per poll item (valve drives, mode, dispensed
//            volume), showing the state after that poll.
//  - cfg_* : target volume in ml. Write only while the block is idle;
//            cfg_ready is always high. A start with a target below 100 ml
//            clears the target.
//  - Pipeline: input register, then result register, which drives out_tvalid.
//            Throughput: 1 item per cycle while out_tready is high; the
//            whole mode and volume update sits between the two registers.
//  - Stall: if out_tready is low the result register holds and the input
//            register still takes one more item; after that in_tready drops.
//  - Reset (rst_n low, synchronous): pipeline empty, target 0, run state
//            cleared, mode stop: the first poll switches all drives off and
//            reports idle.
// ----------------------------------------------------------------------------
module metered_dispense_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  // poll items
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] encoder_step, [7] gun_ready, [8] error_active,
  // [9] start_request, [10] stop_request, [15:11] zero
  input  logic [15:0] in_tdata,
  // status items
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] pump_on, [1] main_valve_on, [2] aux_valve_on, [5:3] mode,
  // [30:6] dispensed_volume, [31] zero
  output logic [31:0] out_tdata,
  // target volume write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);
  import mdc_pkg::*;

  localparam int ITEM_W = $bits(in_item_t);
  localparam int RES_W  = $bits(result_t);

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r;
  result_t  out_r;
  result_t  res;
  logic     advance;
  logic     cfg_we;

  // item moves from the input register into the result register
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata[ITEM_W-1:0]);
    end
  end

  mdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .item     (in_item_r),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(32-RES_W)'(0), out_r};

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for metered_dispense_controller_unit. Poll items go in
// on the in_ stream and every accepted item is run through a local copy of
// the dispense sequencer; the status item that comes back on the out_ stream
// is checked field by field against the oldest prediction. Directed tests
// cover reset, error mode, start rejection, the volume update and the tick
// fold; random dispense runs and a final stop-request test follow, under
// three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdc_pkg::*;

  localparam int HOLD_CYCLES = 64;   // long receiver hold-off
  localparam int DRAIN_GAP   = 4;    // pipeline is 2 deep, leave some slack
  localparam int ITEM_W      = $bits(in_item_t);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;

  metered_dispense_controller_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencer prediction
  // --------------------------------------------------------------------------
  logic [TGT_W-1:0]  tgt_ml;
  logic [MODE_W-1:0] run_mode;
  int                rel_ticks;      // kept in -32767..32768
  logic [31:0]       base_ticks;
  logic [16:0]       part_ticks;
  logic [VOL_W-1:0]  base_ml;
  logic [ML_W-1:0]   part_ml;
  logic              start_latched;
  logic              stop_latched;
  logic [2:0]        drive_bits;

  result_t pending_status[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_sent = 0;
  int mismatch_cnt = 0;
  int hold_req_cnt = 0;
  int hold_done_cnt = 0;
  int hold_left = 0;

  task automatic reset_sequencer();
    tgt_ml        = '0;
    run_mode      = MODE_CODE_STOP;  // first poll turns everything off
    rel_ticks     = 0;
    base_ticks    = '0;
    part_ticks    = '0;
    base_ml       = '0;
    part_ml       = '0;
    start_latched = 1'b0;
    stop_latched  = 1'b0;
    drive_bits    = '0;
  endtask

  // counts within +-10 of zero read as no motion
  function automatic int deadband(input int v);
    return (v >= -10 && v <= 10) ? 0 : v;
  endfunction

  // ticks * 25 / 10, done in 32-bit unsigned like the meter math
  function automatic logic [31:0] ml_of_ticks(input int t);
    logic [31:0] u;
    u = t;
    return (u * 32'd25) / 32'd10;
  endfunction

  function automatic logic [VOL_W-1:0] total_dispensed();
    logic [31:0] s;
    s = 32'(base_ml) + 32'(part_ml);
    return (s > 32'(VOL_MAX)) ? VOL_MAX : s[VOL_W-1:0];
  endfunction

  // One volume update in work mode; returns 1 when the target is reached.
  function automatic bit meter_update();
    int          pre;
    int          f;
    logic [31:0] ml;
    logic [31:0] fast;
    pre = deadband(rel_ticks);
    // backward motion: pull the counter back to the last accepted count
    if (pre < int'(part_ticks))
      rel_ticks = int'(part_ticks);
    // count already matches the total: nothing to do this tick
    if (pre >= 0 && ml_of_ticks(pre) == 32'(total_dispensed()))
      return 1'b0;
    f = deadband(rel_ticks);
    if (f >= int'(FOLD_TICKS)) begin
      // fold partial sums into the bases; no valve or target check now
      rel_ticks  = 0;
      base_ml    = total_dispensed();
      part_ml    = '0;
      base_ticks = base_ticks + 32'(part_ticks);
      part_ticks = '0;
      f          = 0;
    end
    ml = ml_of_ticks(f);
    if (32'(part_ml) == ml)
      return 1'b0;
    part_ml    = ml[ML_W-1:0];
    part_ticks = f[16:0];
    fast = (tgt_ml > SLOW_MARGIN) ? 32'(tgt_ml - SLOW_MARGIN) : 32'd0;
    if (32'(total_dispensed()) >= fast)
      drive_bits[VALVE_MAIN] = 1'b0;
    return 32'(total_dispensed()) >= 32'(tgt_ml);
  endfunction

  function automatic result_t predict_status(input in_item_t it);
    int                acc;
    logic [MODE_W-1:0] nxt;
    result_t           r;
    acc = rel_ticks + int'($signed(it.encoder_step));
    if (acc < int'(REL_MIN))
      acc = int'(REL_MIN);
    if (acc > int'(REL_MAX))
      acc = int'(REL_MAX);
    rel_ticks = acc;

    // start latched first, so a stop in the same item wins
    if (it.start_request)
      start_latched = 1'b1;
    if (it.stop_request) begin
      start_latched = 1'b0;
      stop_latched  = 1'b1;
    end

    nxt = run_mode;
    case (run_mode)
      MODE_CODE_IDLE: begin
        if (it.error_active)
          nxt = MODE_CODE_ERROR;
        else if (stop_latched)
          nxt = MODE_CODE_STOP;
        else if (start_latched)
          nxt = MODE_CODE_START;
      end
      MODE_CODE_START: begin
        if (tgt_ml < MIN_TARGET) begin
          tgt_ml = '0;
          nxt    = MODE_CODE_IDLE;
        end else if (it.gun_ready) begin
          start_latched = 1'b0;
          stop_latched  = 1'b0;
          base_ticks    = '0;
          part_ticks    = '0;
          base_ml       = '0;
          part_ml       = '0;
          rel_ticks     = 0;
          drive_bits    = 3'b111;
          nxt           = MODE_CODE_WORK;
        end
      end
      MODE_CODE_WORK: begin
        if (stop_latched)
          nxt = MODE_CODE_STOP;
        if (!it.gun_ready)
          nxt = MODE_CODE_STOP;
        else if (meter_update())
          nxt = MODE_CODE_STOP;
      end
      MODE_CODE_ERROR: begin
        drive_bits = '0;
        if (!it.error_active)
          nxt = MODE_CODE_IDLE;
      end
      default: begin
        drive_bits = '0;
        nxt        = MODE_CODE_IDLE;
      end
    endcase
    run_mode = nxt;

    r.pump_on          = drive_bits[VALVE_PUMP];
    r.main_valve_on    = drive_bits[VALVE_MAIN];
    r.aux_valve_on     = drive_bits[VALVE_AUX];
    r.mode             = run_mode;
    r.dispensed_volume = total_dispensed();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure plus an occasional counted hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req_cnt != hold_done_cnt) begin
      out_tready    <= 1'b0;
      hold_done_cnt <= hold_req_cnt;
      hold_left     <= HOLD_CYCLES - 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Status check: each accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : status_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[30:0]);
      if (pending_status.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch: status item with none expected, data %h", out_tdata);
      end else begin
        want = pending_status.pop_front();
        check_field("pump_on", want.pump_on, got.pump_on);
        check_field("main_valve_on", want.main_valve_on, got.main_valve_on);
        check_field("aux_valve_on", want.aux_valve_on, got.aux_valve_on);
        check_field("mode", want.mode, got.mode);
        check_field("dispensed_volume", want.dispensed_volume, got.dispensed_volume);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t mk_poll(input int step, input bit gun, input bit err,
                                       input bit start, input bit stop);
    in_item_t it;
    it.encoder_step  = step[STEP_W-1:0];
    it.gun_ready     = gun;
    it.error_active  = err;
    it.start_request = start;
    it.stop_request  = stop;
    return it;
  endfunction

  // all fields random; a stop request would latch for the rest of the run
  function automatic in_item_t rand_poll(input bit allow_stop);
    in_item_t it;
    it = in_item_t'(ITEM_W'($urandom_range(2047, 0)));
    if (!allow_stop)
      it.stop_request = 1'b0;
    return it;
  endfunction

  // mostly forward flow with the gun held, some noise on the other fields
  function automatic in_item_t work_poll();
    in_item_t it;
    int       sel;
    int       step;
    sel = $urandom_range(9, 0);
    if (sel == 0)
      step = $urandom_range(127, 0) - 64;
    else if (sel == 1)
      step = $urandom_range(20, 0) - 10;
    else
      step = $urandom_range(63, 20);
    it = mk_poll(step, $urandom_range(99, 0) < 97, 1'($urandom_range(1, 0)),
                 $urandom_range(9, 0) == 0, 1'b0);
    return it;
  endfunction

  // Offer one item, optionally after a random gap; predict it on accept.
  task automatic send_item(input in_item_t it);
    result_t st;
    if (tx_idle_pct != 0) begin
      while ($urandom_range(99, 0) < tx_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, it};
    do @(posedge clk); while (!in_tready);
    st = predict_status(it);
    pending_status.push_back(st);
    n_sent++;
  endtask

  // stop offering and wait until every predicted status has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [TGT_W-1:0] v);
    wait_idle();
    repeat (DRAIN_GAP) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tgt_ml = v;
    cfg_valid <= 1'b0;
  endtask

  // drive start requests until the sequencer sits in start mode
  task automatic enter_start();
    int n;
    n = 0;
    while (run_mode != MODE_CODE_START && n < 6) begin
      send_item(mk_poll($urandom_range(127, 0) - 64, 1'b0, 1'b0, 1'b1, 1'b0));
      n++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset exit, encoder extremes while idle, error mode entry and exit
  task automatic test_idle_modes();
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(63, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(-64, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(-1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(mk_poll(21, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // targets below 100 bounce back to idle and clear the target; 100 runs
  task automatic test_start_reject();
    cfg_write(24'd0);
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b0, 1'b0));
    cfg_write(24'd99);
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b0, 1'b0));
    cfg_write(24'd100);
    enter_start();
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b0, 1'b0));   // gun open: hold start
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b0, 1'b0));   // into work
    send_item(mk_poll(8, 1'b1, 1'b0, 1'b0, 1'b0));   // inside dead band
    send_item(mk_poll(30, 1'b1, 1'b0, 1'b0, 1'b0));  // main valve closes
    send_item(mk_poll(-64, 1'b1, 1'b0, 1'b0, 1'b0)); // backward, undone
    send_item(mk_poll(2, 1'b1, 1'b0, 1'b0, 1'b0));   // reaches 100 ml
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b0, 1'b0));   // stop then idle
  endtask

  // maximum target, full-speed flow past the fold point, long output stall
  task automatic test_fold();
    cfg_write(24'hFFFFFF);
    enter_start();
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < 490; i++) begin
      if (i == 100)
        hold_req_cnt++;
      send_item(mk_poll(63, 1'b1, 1'($urandom_range(1, 0)), 1'b0, 1'b0));
    end
    send_item(mk_poll(-40, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(12, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b0, 1'b0));    // gun release
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // one random dispense: target, some noise, start, flow until stop
  task automatic run_dispense();
    int               sel;
    int               n;
    logic [TGT_W-1:0] tgt;
    sel = $urandom_range(19, 0);
    if (sel == 0)
      tgt = TGT_W'($urandom_range(99, 0));
    else if (sel == 1)
      tgt = TGT_W'($urandom_range(24'hFFFFFF, 0));
    else if (sel == 2)
      tgt = ($urandom_range(1, 0) != 0) ? 24'd1000 : 24'd1001;
    else
      tgt = TGT_W'($urandom_range(4000, 100));
    cfg_write(tgt);
    if ($urandom_range(3, 0) == 0) begin
      repeat ($urandom_range(4, 1)) send_item(rand_poll(1'b0));
    end
    enter_start();
    if (run_mode == MODE_CODE_START) begin
      if ($urandom_range(3, 0) == 0)
        send_item(mk_poll($urandom_range(127, 0) - 64, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(mk_poll($urandom_range(127, 0) - 64, 1'b1, 1'($urandom_range(1, 0)),
                        1'b0, 1'b0));
    end
    n = 0;
    while (run_mode == MODE_CODE_WORK && n < 150) begin
      send_item(work_poll());
      n++;
    end
  endtask

  // stop requests latch for good, so they come last
  task automatic test_stop_request();
    cfg_write(24'd500);
    enter_start();
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (3) send_item(mk_poll(30, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_poll(30, 1'b1, 1'b0, 1'b0, 1'b1));  // stop with gun held
    send_item(mk_poll(0, 1'b1, 1'b0, 1'b1, 1'b1));   // both requests at once
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk_poll(0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(mk_poll(0, 1'b0, 1'b0, 1'b0, 1'b0));
    repeat (40) send_item(rand_poll(1'b1));
  endtask

  initial begin
    reset_sequencer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender gaps light, receiver stalls heavy
    tx_idle_pct = 33;
    rx_idle_pct = 56;
    test_idle_modes();
    test_start_reject();
    test_fold();

    // roles swapped
    tx_idle_pct = 56;
    rx_idle_pct = 33;
    hold_req_cnt++;
    while (n_sent < 780)
      run_dispense();

    // back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (n_sent < 950)
      run_dispense();
    test_stop_request();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_status.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
